// File: design/assert_macros.svh
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// File: design/jbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jbc_pkg;

	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] CfgJoyXOffset = 3'd0;
	localparam logic [CfgIdxW-1:0] CfgJoyYOffset = 3'd1;
	localparam logic [CfgIdxW-1:0] CfgAccelOffset = 3'd2;
	localparam logic [CfgIdxW-1:0] CfgAccelLimit = 3'd3;
	localparam logic [CfgIdxW-1:0] CfgAccelReverse = 3'd4;
	localparam logic [CfgIdxW-1:0] CfgDebounceMs = 3'd5;
	localparam logic [CfgIdxW-1:0] CfgHoldMs = 3'd6;

	localparam logic [7:0] RstJoyOffset = 8'd127;
	localparam logic [9:0] RstAccelOffset = 10'd512;
	localparam logic [8:0] RstAccelLimit = 9'd200;
	localparam logic [15:0] RstDebounceMs = 16'd50;
	localparam logic [15:0] RstHoldMs = 16'd1000;

	localparam logic signed [11:0] JoyCenter = 12'sd127;
	localparam logic [6:0] JoyDeadband = 7'd15;
	localparam logic [6:0] AccDeadband = 7'd100;
	localparam logic signed [7:0] LockThreshold = 8'sd83;
	localparam logic [7:0] LockMax = 8'd250;

	typedef struct packed {
		logic [15:0] debounce_ms;
		logic [15:0] hold_ms;
	} btn_cfg_t;

	function automatic logic signed [11:0] clamp_sym(logic signed [11:0] v,
			logic signed [11:0] lim);
		logic signed [11:0] lo;
		logic signed [11:0] r;
		lo = -lim;
		priority if (v < lo) begin
			r = lo;
		end else if (v > lim) begin
			r = lim;
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic signed [11:0] dead_zone(logic signed [11:0] v, logic [6:0] t);
		logic signed [11:0] tv;
		logic signed [11:0] r;
		tv = $signed({5'b0, t});
		priority if (v >= tv) begin
			r = v - tv;
		end else if (v <= -tv) begin
			r = v + tv;
		end else begin
			r = '0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: design/jbc_joy_axis.sv
`timescale 1ns / 1ps
`default_nettype none

module jbc_joy_axis import jbc_pkg::*; (
	input  logic              [7:0] raw,
	input  logic              [7:0] offset,
	output logic signed       [7:0] axis
);

	logic signed [11:0] diff;
	logic signed [11:0] ctr;
	logic signed [11:0] ctr_abs;
	logic signed [11:0] lim;
	logic signed [11:0] shaped;

	always_comb begin
		diff = $signed({4'b0, raw}) - $signed({4'b0, offset});
		ctr = JoyCenter - $signed({4'b0, offset});
		ctr_abs = (ctr < 0) ? -ctr : ctr;
		lim = JoyCenter - ctr_abs;
		shaped = dead_zone(clamp_sym(diff, lim), JoyDeadband);
	end

	assign axis = shaped[7:0];

endmodule

`default_nettype wire

// File: design/jbc_button.sv
`timescale 1ns / 1ps
`default_nettype none

module jbc_button import jbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        pressed,
	input  logic [31:0] now_ms,
	input  btn_cfg_t    cfg,
	output logic [1:0]  state_next
);

	typedef enum logic [1:0] {
		ReadAgain = 2'd0,
		Released  = 2'd1,
		Pressed   = 2'd2,
		Held      = 2'd3
	} btn_state_t;

	btn_state_t  state_q;
	btn_state_t  state_d;
	logic [31:0] last_q;
	logic [31:0] last_d;
	logic [31:0] elapsed;
	logic        debounced;
	logic        hold_done;

	always_comb begin
		elapsed = now_ms - last_q;
		debounced = elapsed > {16'b0, cfg.debounce_ms};
		hold_done = elapsed > {16'b0, cfg.hold_ms};
		state_d = state_q;
		last_d = last_q;
		if (debounced) begin
			unique case (state_q)
				ReadAgain: begin
					if (!pressed) begin
						state_d = Released;
						last_d = now_ms;
					end
				end
				Released: begin
					if (pressed) begin
						state_d = Pressed;
						last_d = now_ms;
					end
				end
				Pressed, Held: begin
					if (!pressed) begin
						state_d = Released;
						last_d = now_ms;
					end else if (hold_done) begin
						state_d = Held;
					end
				end
			endcase
		end
	end

	assign state_next = state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ReadAgain;
			last_q <= '0;
		end else if (step) begin
			state_q <= state_d;
			last_q <= last_d;
		end
	end

endmodule

`default_nettype wire

// File: design/joystick_and_button_conditioner_unit.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Controller sample conditioner. Each accepted item is one controller sample
// and yields exactly one result item: centered, clamped and deadbanded joystick
// and accelerometer axes, per-axis lock counts and debounced C/Z button states.
// An item passes an input register and a result register; its result is
// offered once the result register has room. One item can be accepted every
// cycle unless the output stalls: all work for an item is one pass of add,
// compare and clamp logic. The input register keeps taking items while a
// result waits, until it too is full. Configuration writes are always ready
// and take effect at once; write them only while no item is in flight.
module joystick_and_button_conditioner_unit import jbc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                in_valid,
	output logic                in_stall,
	input  logic          [7:0] raw_joy_x,
	input  logic          [7:0] raw_joy_y,
	input  logic          [9:0] raw_accel_x,
	input  logic                c_pressed,
	input  logic                z_pressed,
	input  logic         [31:0] now_ms,

	output logic                out_valid,
	input  logic                out_stall,
	output logic signed   [7:0] joy_x_out,
	output logic signed   [7:0] joy_y_out,
	output logic signed   [9:0] accel_out,
	output logic          [7:0] x_lock_out,
	output logic          [7:0] y_lock_out,
	output logic          [1:0] c_state_out,
	output logic          [1:0] z_state_out,

	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic  [CfgIdxW-1:0] cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	logic [7:0]  joy_x_offset_q;
	logic [7:0]  joy_y_offset_q;
	logic [9:0]  accel_offset_q;
	logic [8:0]  accel_limit_q;
	logic        accel_reverse_q;
	btn_cfg_t    btn_cfg_q;

	logic        valid_s1;
	logic [7:0]  raw_joy_x_s1;
	logic [7:0]  raw_joy_y_s1;
	logic [9:0]  raw_accel_x_s1;
	logic        c_pressed_s1;
	logic        z_pressed_s1;
	logic [31:0] now_ms_s1;

	logic        out_valid_q;
	logic signed [7:0] joy_x_q;
	logic signed [7:0] joy_y_q;
	logic signed [9:0] accel_q;
	logic [7:0]  x_lock_q;
	logic [7:0]  y_lock_q;
	logic [1:0]  c_state_q;
	logic [1:0]  z_state_q;

	logic        advance;
	logic        take_in;
	logic signed [7:0] joy_x_d;
	logic signed [7:0] joy_y_d;
	logic signed [11:0] acc_diff;
	logic signed [11:0] acc_clamped;
	logic signed [11:0] acc_dir;
	logic signed [11:0] acc_shaped;
	logic [7:0]  x_lock_d;
	logic [7:0]  y_lock_d;
	logic [1:0]  c_state_d;
	logic [1:0]  z_state_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joy_x_offset_q <= RstJoyOffset;
			joy_y_offset_q <= RstJoyOffset;
			accel_offset_q <= RstAccelOffset;
			accel_limit_q <= RstAccelLimit;
			accel_reverse_q <= 1'b0;
			btn_cfg_q.debounce_ms <= RstDebounceMs;
			btn_cfg_q.hold_ms <= RstHoldMs;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CfgJoyXOffset:   joy_x_offset_q <= cfg_data[7:0];
				CfgJoyYOffset:   joy_y_offset_q <= cfg_data[7:0];
				CfgAccelOffset:  accel_offset_q <= cfg_data[9:0];
				CfgAccelLimit:   accel_limit_q <= cfg_data[8:0];
				CfgAccelReverse: accel_reverse_q <= cfg_data[0];
				CfgDebounceMs:   btn_cfg_q.debounce_ms <= cfg_data[15:0];
				CfgHoldMs:       btn_cfg_q.hold_ms <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// advance the input register into the result register when it has room
	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take_in = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			raw_joy_x_s1 <= raw_joy_x;
			raw_joy_y_s1 <= raw_joy_y;
			raw_accel_x_s1 <= raw_accel_x;
			c_pressed_s1 <= c_pressed;
			z_pressed_s1 <= z_pressed;
			now_ms_s1 <= now_ms;
		end
	end

	jbc_joy_axis u_joy_x (
		.raw    (raw_joy_x_s1),
		.offset (joy_x_offset_q),
		.axis   (joy_x_d)
	);

	jbc_joy_axis u_joy_y (
		.raw    (raw_joy_y_s1),
		.offset (joy_y_offset_q),
		.axis   (joy_y_d)
	);

	always_comb begin
		acc_diff = $signed({2'b0, raw_accel_x_s1}) - $signed({2'b0, accel_offset_q});
		acc_clamped = clamp_sym(acc_diff, $signed({3'b0, accel_limit_q}));
		acc_dir = accel_reverse_q ? -acc_clamped : acc_clamped;
		acc_shaped = dead_zone(acc_dir, AccDeadband);
	end

	always_comb begin
		if (joy_x_d > LockThreshold || joy_x_d < -LockThreshold) begin
			x_lock_d = (x_lock_q >= LockMax) ? LockMax : x_lock_q + 8'd1;
		end else begin
			x_lock_d = '0;
		end
		if (joy_y_d > LockThreshold || joy_y_d < -LockThreshold) begin
			y_lock_d = (y_lock_q >= LockMax) ? LockMax : y_lock_q + 8'd1;
		end else begin
			y_lock_d = '0;
		end
	end

	jbc_button u_btn_c (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.pressed    (c_pressed_s1),
		.now_ms     (now_ms_s1),
		.cfg        (btn_cfg_q),
		.state_next (c_state_d)
	);

	jbc_button u_btn_z (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.pressed    (z_pressed_s1),
		.now_ms     (now_ms_s1),
		.cfg        (btn_cfg_q),
		.state_next (z_state_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			x_lock_q <= '0;
			y_lock_q <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				x_lock_q <= x_lock_d;
				y_lock_q <= y_lock_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			joy_x_q <= joy_x_d;
			joy_y_q <= joy_y_d;
			accel_q <= acc_shaped[9:0];
			c_state_q <= c_state_d;
			z_state_q <= z_state_d;
		end
	end

	assign out_valid = out_valid_q;
	assign joy_x_out = joy_x_q;
	assign joy_y_out = joy_y_q;
	assign accel_out = accel_q;
	assign x_lock_out = x_lock_q;
	assign y_lock_out = y_lock_q;
	assign c_state_out = c_state_q;
	assign z_state_out = z_state_q;

	`ASSERT_NEVER(a_lock_max, clk, arst_n, x_lock_q > LockMax || y_lock_q > LockMax)
	`ASSERT_NEVER(a_no_overrun, clk, arst_n, take_in && valid_s1 && out_valid_q && out_stall)
	`ASSERT_CLK(a_out_src, clk, arst_n, $rose(out_valid_q) |-> $past(valid_s1))
	`ASSERT_CLK(a_joy_range, clk, arst_n, out_valid_q |-> (joy_x_q >= -8'sd112 && joy_x_q <= 8'sd112))

endmodule

`default_nettype wire

// File: bench/tb_joystick_and_button_conditioner_unit.sv
`timescale 1ns / 1ps

module tb_joystick_and_button_conditioner_unit;
	import jbc_pkg::*;

	localparam int JoyDead = 15;
	localparam int AccDead = 100;
	localparam int LockLevel = 83;
	localparam int LockSat = 250;
	localparam int CycleLimit = 400000;
	localparam logic [CfgIdxW-1:0] CfgSpare = 3'd7;

	typedef enum logic [1:0] {
		BtnReadAgain = 2'd0,
		BtnReleased = 2'd1,
		BtnPressed = 2'd2,
		BtnHeld = 2'd3
	} btn_state_t;

	typedef struct {
		logic [7:0] raw_x;
		logic [7:0] raw_y;
		logic [9:0] raw_acc;
		logic c_lvl;
		logic z_lvl;
		logic [31:0] stamp;
	} sample_t;

	typedef struct {
		logic signed [7:0] jx;
		logic signed [7:0] jy;
		logic signed [9:0] ax;
		logic [7:0] xl;
		logic [7:0] yl;
		btn_state_t cs;
		btn_state_t zs;
	} cond_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [7:0] raw_joy_x;
	logic [7:0] raw_joy_y;
	logic [9:0] raw_accel_x;
	logic c_pressed;
	logic z_pressed;
	logic [31:0] now_ms;
	logic out_valid;
	logic out_stall;
	logic signed [7:0] joy_x_out;
	logic signed [7:0] joy_y_out;
	logic signed [9:0] accel_out;
	logic [7:0] x_lock_out;
	logic [7:0] y_lock_out;
	logic [1:0] c_state_out;
	logic [1:0] z_state_out;
	logic cfg_valid;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	logic [7:0] m_joy_x_off = 8'd127;
	logic [7:0] m_joy_y_off = 8'd127;
	logic [9:0] m_accel_off = 10'd512;
	logic [8:0] m_accel_lim = 9'd200;
	logic m_accel_rev = 1'b0;
	logic [15:0] m_debounce = 16'd50;
	logic [15:0] m_hold = 16'd1000;

	btn_state_t c_btn = BtnReadAgain;
	btn_state_t z_btn = BtnReadAgain;
	logic [31:0] c_since = '0;
	logic [31:0] z_since = '0;
	logic [7:0] x_lock_cnt = '0;
	logic [7:0] y_lock_cnt = '0;

	cond_t pending_cond[$];

	logic [31:0] run_stamp;
	logic run_c;
	logic run_z;
	int step_max;
	bit steady = 1'b0;

	int mismatches = 0;
	int samples_sent = 0;
	int results_checked = 0;
	int reg_writes = 0;
	int settings_used = 0;
	int cycle_count = 0;

	joystick_and_button_conditioner_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.raw_joy_x(raw_joy_x),
		.raw_joy_y(raw_joy_y),
		.raw_accel_x(raw_accel_x),
		.c_pressed(c_pressed),
		.z_pressed(z_pressed),
		.now_ms(now_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.joy_x_out(joy_x_out),
		.joy_y_out(joy_y_out),
		.accel_out(accel_out),
		.x_lock_out(x_lock_out),
		.y_lock_out(y_lock_out),
		.c_state_out(c_state_out),
		.z_state_out(z_state_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic int magnitude(int v);
		return v < 0 ? -v : v;
	endfunction

	function automatic int clamp_to(int v, int lim);
		int lo;
		lo = -lim;
		if (v < lo)
			return lo;
		if (v > lim)
			return lim;
		return v;
	endfunction

	function automatic int trim_deadband(int v, int t);
		if (magnitude(v) < t)
			return 0;
		return v >= t ? v - t : v + t;
	endfunction

	function automatic int center_joy(logic [7:0] raw, logic [7:0] off);
		int span;
		span = 127 - magnitude(127 - int'(off));
		return trim_deadband(clamp_to(int'(raw) - int'(off), span), JoyDead);
	endfunction

	function automatic logic [7:0] count_lock(logic [7:0] cnt, int v);
		if (magnitude(v) > LockLevel)
			return cnt >= LockSat ? 8'(LockSat) : cnt + 8'd1;
		return 8'd0;
	endfunction

	task automatic advance_button(input logic lvl, input logic [31:0] stamp,
			inout btn_state_t st, inout logic [31:0] since);
		logic [31:0] elapsed;
		elapsed = stamp - since;
		if (elapsed > m_debounce) begin
			case (st)
				BtnReadAgain: begin
					if (!lvl) begin
						st = BtnReleased;
						since = stamp;
					end
				end
				BtnReleased: begin
					if (lvl) begin
						st = BtnPressed;
						since = stamp;
					end
				end
				default: begin
					if (!lvl) begin
						st = BtnReleased;
						since = stamp;
					end else if (elapsed > m_hold) begin
						st = BtnHeld;
					end
				end
			endcase
		end
	endtask

	task automatic condition_sample(input sample_t s, output cond_t r);
		int jx;
		int jy;
		int ax;
		jx = center_joy(s.raw_x, m_joy_x_off);
		jy = center_joy(s.raw_y, m_joy_y_off);
		ax = clamp_to(int'(s.raw_acc) - int'(m_accel_off), int'(m_accel_lim));
		if (m_accel_rev)
			ax = -ax;
		ax = trim_deadband(ax, AccDead);
		x_lock_cnt = count_lock(x_lock_cnt, jx);
		y_lock_cnt = count_lock(y_lock_cnt, jy);
		advance_button(s.c_lvl, s.stamp, c_btn, c_since);
		advance_button(s.z_lvl, s.stamp, z_btn, z_since);
		r.jx = jx[7:0];
		r.jy = jy[7:0];
		r.ax = ax[9:0];
		r.xl = x_lock_cnt;
		r.yl = y_lock_cnt;
		r.cs = c_btn;
		r.zs = z_btn;
	endtask

	task automatic check_field(input string label, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0d got %0d", $time, label, want, got);
		end
	endtask

	always @(posedge clk) begin
		cond_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (pending_cond.size() == 0) begin
				mismatches++;
				$display("%0t: result item with no sample pending", $time);
			end else begin
				want = pending_cond.pop_front();
				check_field("joy_x_out", want.jx, joy_x_out);
				check_field("joy_y_out", want.jy, joy_y_out);
				check_field("accel_out", want.ax, accel_out);
				check_field("x_lock_out", want.xl, x_lock_out);
				check_field("y_lock_out", want.yl, y_lock_out);
				check_field("c_state_out", want.cs, c_state_out);
				check_field("z_state_out", want.zs, z_state_out);
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("%0t: timeout, %0d results still pending", $time, pending_cond.size());
			$display("joystick_and_button_conditioner_unit verification failed");
			$finish;
		end
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!steady && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_sample(input sample_t s);
		cond_t want;
		if (!steady && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		raw_joy_x <= s.raw_x;
		raw_joy_y <= s.raw_y;
		raw_accel_x <= s.raw_acc;
		c_pressed <= s.c_lvl;
		z_pressed <= s.z_lvl;
		now_ms <= s.stamp;
		do @(posedge clk); while (in_stall);
		condition_sample(s, want);
		pending_cond.push_back(want);
		samples_sent++;
	endtask

	task automatic send_fields(input logic [7:0] x, input logic [7:0] y,
			input logic [9:0] a, input logic c, input logic z, input logic [31:0] stamp);
		sample_t s;
		s.raw_x = x;
		s.raw_y = y;
		s.raw_acc = a;
		s.c_lvl = c;
		s.z_lvl = z;
		s.stamp = stamp;
		send_sample(s);
	endtask

	task automatic wait_all_results;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_cond.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx,
			input logic [CfgDataW-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CfgJoyXOffset: m_joy_x_off = data[7:0];
			CfgJoyYOffset: m_joy_y_off = data[7:0];
			CfgAccelOffset: m_accel_off = data[9:0];
			CfgAccelLimit: m_accel_lim = data[8:0];
			CfgAccelReverse: m_accel_rev = data[0];
			CfgDebounceMs: m_debounce = data;
			CfgHoldMs: m_hold = data;
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic end_writes;
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic program_all(input logic [7:0] xo, input logic [7:0] yo,
			input logic [9:0] ao, input logic [8:0] al, input logic rev,
			input logic [15:0] deb, input logic [15:0] hold);
		logic [15:0] junk;
		junk = 16'($urandom());
		write_reg(CfgJoyXOffset, {junk[15:8], xo});
		write_reg(CfgJoyYOffset, {junk[7:0], yo});
		write_reg(CfgAccelOffset, {junk[5:0], ao});
		write_reg(CfgAccelLimit, {junk[15:9], al});
		write_reg(CfgAccelReverse, {junk[14:0], rev});
		write_reg(CfgDebounceMs, deb);
		write_reg(CfgHoldMs, hold);
		write_reg(CfgSpare, junk);
		end_writes();
		run_stamp = $urandom();
		run_c = 1'($urandom_range(0, 1));
		run_z = 1'($urandom_range(0, 1));
		step_max = int'(m_debounce) + int'(m_hold) / 4 + 10;
	endtask

	task automatic random_settings(input int kind);
		logic [15:0] deb;
		logic [15:0] hold;
		case (kind)
			0: program_all(8'd0, 8'd0, 10'd0, 9'd0, 1'b0, 16'd0, 16'd0);
			1: program_all(8'd255, 8'd255, 10'd1023, 9'd511, 1'b1, 16'hFFFF, 16'hFFFF);
			default: begin
				deb = $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom_range(0, 120));
				hold = $urandom_range(0, 4) == 0 ? 16'hFFFF : 16'($urandom_range(0, 600));
				program_all(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					10'($urandom_range(0, 1023)), 9'($urandom_range(0, 511)),
					1'($urandom_range(0, 1)), deb, hold);
			end
		endcase
	endtask

	function automatic logic [7:0] pick_joy(logic [7:0] off);
		int v;
		case ($urandom_range(0, 2))
			0: v = $urandom_range(0, 255);
			1: v = $urandom_range(0, 1) ? $urandom_range(243, 255) : $urandom_range(0, 12);
			default: v = int'(off) + int'($urandom_range(0, 80)) - 40;
		endcase
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[7:0];
	endfunction

	function automatic logic [9:0] pick_accel(logic [9:0] off);
		int v;
		case ($urandom_range(0, 2))
			0: v = $urandom_range(0, 1023);
			1: v = $urandom_range(0, 1) ? $urandom_range(983, 1023) : $urandom_range(0, 40);
			default: v = int'(off) + int'($urandom_range(0, 600)) - 300;
		endcase
		if (v < 0)
			v = 0;
		if (v > 1023)
			v = 1023;
		return v[9:0];
	endfunction

	task automatic make_sample(input bit deflect, output sample_t s);
		if ($urandom_range(0, 19) == 0) begin
			s.stamp = $urandom();
			s.c_lvl = 1'($urandom_range(0, 1));
			s.z_lvl = 1'($urandom_range(0, 1));
		end else begin
			run_stamp += $urandom_range(0, step_max);
			if ($urandom_range(0, 4) == 0)
				run_c = !run_c;
			if ($urandom_range(0, 4) == 0)
				run_z = !run_z;
			s.stamp = run_stamp;
			s.c_lvl = run_c;
			s.z_lvl = run_z;
		end
		if (deflect) begin
			s.raw_x = 8'($urandom_range(240, 255));
			s.raw_y = 8'($urandom_range(0, 15));
		end else begin
			s.raw_x = pick_joy(m_joy_x_off);
			s.raw_y = pick_joy(m_joy_y_off);
		end
		s.raw_acc = pick_accel(m_accel_off);
	endtask

	task automatic test_field_extremes;
		send_fields(8'd0, 8'd0, 10'd0, 1'b0, 1'b0, 32'd0);
		send_fields(8'd255, 8'd255, 10'd1023, 1'b1, 1'b1, 32'd1);
		send_fields(8'd127, 8'd127, 10'd512, 1'b0, 1'b1, 32'd2);
		send_fields(8'd142, 8'd112, 10'd612, 1'b1, 1'b0, 32'd3);
		send_fields(8'd143, 8'd111, 10'd300, 1'b0, 1'b0, 32'd4);
		send_fields(8'd16, 8'd240, 10'd713, 1'b1, 1'b1, 32'd5);
	endtask

	task automatic test_button_sequences;
		send_fields(8'd127, 8'd127, 10'd512, 1'b0, 1'b0, 32'd10);
		send_fields(8'd127, 8'd127, 10'd512, 1'b0, 1'b1, 32'd51);
		send_fields(8'd127, 8'd127, 10'd512, 1'b1, 1'b0, 32'd80);
		send_fields(8'd127, 8'd127, 10'd512, 1'b1, 1'b1, 32'd102);
		send_fields(8'd127, 8'd127, 10'd512, 1'b1, 1'b1, 32'd131);
		send_fields(8'd127, 8'd127, 10'd512, 1'b1, 1'b1, 32'd1103);
		send_fields(8'd127, 8'd127, 10'd512, 1'b0, 1'b1, 32'd1132);
		send_fields(8'd127, 8'd127, 10'd512, 1'b1, 1'b0, 32'hFFFF_FFF0);
		send_fields(8'd127, 8'd127, 10'd512, 1'b1, 1'b1, 32'h0000_0030);
	endtask

	task automatic test_register_extremes;
		wait_all_results();
		write_reg(CfgJoyXOffset, 16'h00FF);
		write_reg(CfgJoyYOffset, 16'h0000);
		write_reg(CfgAccelOffset, 16'h0000);
		write_reg(CfgAccelLimit, 16'h0000);
		write_reg(CfgAccelReverse, 16'h0001);
		write_reg(CfgDebounceMs, 16'h0000);
		write_reg(CfgHoldMs, 16'h0000);
		write_reg(CfgSpare, 16'hFFFF);
		end_writes();
		send_fields(8'd0, 8'd255, 10'd1023, 1'b1, 1'b0, 32'd2000);
		send_fields(8'd255, 8'd0, 10'd0, 1'b0, 1'b1, 32'd2001);
		send_fields(8'd254, 8'd1, 10'd512, 1'b1, 1'b1, 32'd2002);
		wait_all_results();
		write_reg(CfgJoyXOffset, 16'hFF80);
		write_reg(CfgJoyYOffset, 16'h7F7F);
		write_reg(CfgAccelOffset, 16'hFFFF);
		write_reg(CfgAccelLimit, 16'hFFFF);
		write_reg(CfgAccelReverse, 16'h0003);
		write_reg(CfgDebounceMs, 16'hFFFF);
		write_reg(CfgHoldMs, 16'hFFFF);
		end_writes();
		send_fields(8'd0, 8'd255, 10'd0, 1'b1, 1'b1, 32'hFFFF_FFFF);
		send_fields(8'd255, 8'd0, 10'd1023, 1'b0, 1'b0, 32'h0001_0000);
		send_fields(8'd200, 8'd50, 10'd600, 1'b1, 1'b0, 32'h8000_0000);
		wait_all_results();
	endtask

	task automatic test_lock_saturation;
		sample_t s;
		program_all(8'd127, 8'd127, 10'd512, 9'd200, 1'b0, 16'd50, 16'd400);
		for (int i = 0; i < 275; i++) begin
			make_sample(i < 265, s);
			if (i == 262)
				s.raw_y = 8'd127;
			send_sample(s);
		end
		wait_all_results();
	endtask

	task automatic test_random_settings;
		sample_t s;
		for (int p = 0; p < 9; p++) begin
			random_settings(p);
			for (int i = 0; i < 100; i++) begin
				make_sample(1'b0, s);
				send_sample(s);
				if (p == 4 && i == 50)
					wait_all_results();
			end
			wait_all_results();
		end
	endtask

	task automatic test_steady_stream;
		sample_t s;
		steady = 1'b1;
		random_settings(2);
		for (int i = 0; i < 100; i++) begin
			make_sample(1'b0, s);
			send_sample(s);
		end
		wait_all_results();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		raw_joy_x = '0;
		raw_joy_y = '0;
		raw_accel_x = '0;
		c_pressed = 1'b0;
		z_pressed = 1'b0;
		now_ms = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_field_extremes();
		test_button_sequences();
		test_register_extremes();
		test_lock_saturation();
		test_random_settings();
		test_steady_stream();

		repeat (8) @(posedge clk);
		$display("Checked %0d conditioned results from %0d controller samples.",
			results_checked, samples_sent);
		$display("Made %0d register writes over %0d settings, extremes and spare index included.",
			reg_writes, settings_used);
		if (mismatches == 0 && pending_cond.size() == 0)
			$display("joystick_and_button_conditioner_unit verification clean");
		else
			$display("joystick_and_button_conditioner_unit verification failed");
		$finish;
	end

endmodule

// File: joystick_and_button_conditioner_unit.f
+incdir+design
design/jbc_pkg.sv
design/jbc_joy_axis.sv
design/jbc_button.sv
design/joystick_and_button_conditioner_unit.sv
bench/tb_joystick_and_button_conditioner_unit.sv
